>>> design/v3n_pkg.sv
// Shared types and constants for the 3D vector normalizer.
package v3n_pkg;

  // lanes, one per vector component
  localparam int NLANE = 3;

  // quotient c^2 * 2^60 / S is at most 2^60
  localparam int QUO_W     = 61;
  // one restoring step for the leading bit, then one per fraction bit
  localparam int DIV_STEPS = QUO_W;
  // radicand of the unit root, padded to an even width
  localparam int URAD_W    = QUO_W + 1;
  localparam int UROOT_W   = URAD_W / 2;
  localparam int UNIT_W    = 32;
  localparam int MAG_W     = 32;

  // per-item flags carried alongside the datapath
  typedef struct packed {
    logic [NLANE-1:0] neg;
    logic             zero;
  } lane_flags_t;

endpackage

>>> design/v3n_div_cell.sv
// One restoring divide step for all three lanes, registered, divisor carried along.
module v3n_div_cell #(
  parameter int SW    = 66,
  parameter bit SHIFT = 1'b1
) (
  input  logic                                          clk,
  input  logic                                          en,
  input  logic [SW-1:0]                                 d_in,
  input  logic [v3n_pkg::NLANE-1:0][SW:0]               rem_in,
  input  logic [v3n_pkg::NLANE-1:0][v3n_pkg::QUO_W-1:0] quo_in,
  output logic [SW-1:0]                                 d_out,
  output logic [v3n_pkg::NLANE-1:0][SW:0]               rem_out,
  output logic [v3n_pkg::NLANE-1:0][v3n_pkg::QUO_W-1:0] quo_out
);
  import v3n_pkg::*;

  logic [NLANE-1:0][SW:0]       rem_next;
  logic [NLANE-1:0][QUO_W-1:0]  quo_next;
  logic [NLANE-1:0][SW:0]       rs;
  logic [NLANE-1:0]             ge;

  // shift, trial subtract, keep if non-negative
  always_comb begin
    for (int l = 0; l < NLANE; l++) begin
      rs[l]       = SHIFT ? {rem_in[l][SW-1:0], 1'b0} : rem_in[l];
      ge[l]       = rs[l] >= {1'b0, d_in};
      rem_next[l] = ge[l] ? (rs[l] - {1'b0, d_in}) : rs[l];
      quo_next[l] = {quo_in[l][QUO_W-2:0], ge[l]};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_out   <= d_in;
      rem_out <= rem_next;
      quo_out <= quo_next;
    end
  end

endmodule

>>> design/v3n_sqrt_cell.sv
// One digit-by-digit square root step, registered, radicand shifted along.
module v3n_sqrt_cell #(
  parameter int N = 62,
  parameter int R = N / 2
) (
  input  logic         clk,
  input  logic         en,
  input  logic [N-1:0] rad_in,
  input  logic [R+1:0] rem_in,
  input  logic [R-1:0] root_in,
  output logic [N-1:0] rad_out,
  output logic [R+1:0] rem_out,
  output logic [R-1:0] root_out
);

  logic [R+1:0] rs;
  logic [R+1:0] trial;
  logic         ge;

  // bring down two radicand bits, try root*4+1
  always_comb begin
    rs    = {rem_in[R-1:0], rad_in[N-1:N-2]};
    trial = {root_in, 2'b01};
    ge    = rs >= trial;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rad_out  <= {rad_in[N-3:0], 2'b00};
      rem_out  <= ge ? (rs - trial) : rs;
      root_out <= {root_in[R-2:0], ge};
    end
  end

endmodule

>>> design/vector3_normalize.sv
// Top level: pipelined 3D vector normalizer built from rows of divide and root cells.
// The pipeline depth does not depend on IN_WIDTH.
// Throughput: one vector per cycle while the output is not stalled; the depth is set by the
// 61-cell divide row and the 31-cell unit root row, each cell resolving one result bit.
// The whole pipeline holds while a result is stalled at the output.
// Reset (rst, synchronous) clears only the valid bits; payload registers are not reset.
module vector3_normalize #(
  parameter int IN_WIDTH = 32
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               vec_valid,
  output logic                               vec_stall,
  input  logic signed [IN_WIDTH-1:0]         vec_x,
  input  logic signed [IN_WIDTH-1:0]         vec_y,
  input  logic signed [IN_WIDTH-1:0]         vec_z,
  output logic                               unit_valid,
  input  logic                               unit_stall,
  output logic signed [v3n_pkg::UNIT_W-1:0]  unit_x,
  output logic signed [v3n_pkg::UNIT_W-1:0]  unit_y,
  output logic signed [v3n_pkg::UNIT_W-1:0]  unit_z,
  output logic [v3n_pkg::MAG_W-1:0]          magnitude,
  output logic                               zero_vector
);
  import v3n_pkg::*;

  localparam int W         = IN_WIDTH;
  localparam int SW        = 2 * W + 2;
  localparam int MAGR      = W + 1;
  localparam int TOT       = DIV_STEPS + UROOT_W;
  localparam int NSTAGE    = 3 + TOT;
  localparam int MAG_DELAY = TOT - MAGR;

  logic en;
  logic [NSTAGE-1:0] vld;

  // whole pipeline advances unless the result is held
  assign en         = !(vld[NSTAGE-1] && unit_stall);
  assign vec_stall  = !en;
  assign unit_valid = vld[NSTAGE-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[NSTAGE-2:0], vec_valid};
    end
  end

  // stage 0: absolute values and flags
  logic [NLANE-1:0][W-1:0] in_c;
  logic [NLANE-1:0][W-1:0] s0_abs;
  lane_flags_t             fl_s0, fl_s1, fl_s2;

  assign in_c[0] = vec_x;
  assign in_c[1] = vec_y;
  assign in_c[2] = vec_z;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int l = 0; l < NLANE; l++) begin
        s0_abs[l]    <= in_c[l][W-1] ? (~in_c[l] + 1'b1) : in_c[l];
        fl_s0.neg[l] <= in_c[l][W-1];
      end
      fl_s0.zero <= (in_c[0] == '0) && (in_c[1] == '0) && (in_c[2] == '0);
    end
  end

  // stage 1: squares
  logic [NLANE-1:0][2*W-1:0] s1_sq;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int l = 0; l < NLANE; l++) begin
        s1_sq[l] <= (2 * W)'(s0_abs[l]) * (2 * W)'(s0_abs[l]);
      end
      fl_s1 <= fl_s0;
    end
  end

  // stage 2: sum of squares
  logic [SW-1:0]               s2_sum;
  logic [NLANE-1:0][SW:0]      s2_rem;

  always_ff @(posedge clk) begin
    if (en) begin
      s2_sum <= SW'(s1_sq[0]) + SW'(s1_sq[1]) + SW'(s1_sq[2]);
      for (int l = 0; l < NLANE; l++) begin
        s2_rem[l] <= (SW + 1)'(s1_sq[l]);
      end
      fl_s2 <= fl_s1;
    end
  end

  // divide row: quotient c^2 * 2^60 / S per lane
  logic [SW-1:0]                    dv_d   [DIV_STEPS+1];
  logic [NLANE-1:0][SW:0]           dv_rem [DIV_STEPS+1];
  logic [NLANE-1:0][QUO_W-1:0]      dv_quo [DIV_STEPS+1];

  assign dv_d[0]   = s2_sum;
  assign dv_rem[0] = s2_rem;
  assign dv_quo[0] = '0;

  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
    v3n_div_cell #(
      .SW    (SW),
      .SHIFT ((k == 0) ? 1'b0 : 1'b1)
    ) u_cell (
      .clk     (clk),
      .en      (en),
      .d_in    (dv_d[k]),
      .rem_in  (dv_rem[k]),
      .quo_in  (dv_quo[k]),
      .d_out   (dv_d[k+1]),
      .rem_out (dv_rem[k+1]),
      .quo_out (dv_quo[k+1])
    );
  end

  // unit root rows, one per lane
  logic [NLANE-1:0][UROOT_W-1:0] u_root;

  for (genvar l = 0; l < NLANE; l++) begin : g_lane
    logic [URAD_W-1:0]  ur_rad  [UROOT_W+1];
    logic [UROOT_W+1:0] ur_rem  [UROOT_W+1];
    logic [UROOT_W-1:0] ur_root [UROOT_W+1];

    assign ur_rad[0]  = {1'b0, dv_quo[DIV_STEPS][l]};
    assign ur_rem[0]  = '0;
    assign ur_root[0] = '0;

    for (genvar k = 0; k < UROOT_W; k++) begin : g_step
      v3n_sqrt_cell #(
        .N (URAD_W),
        .R (UROOT_W)
      ) u_cell (
        .clk      (clk),
        .en       (en),
        .rad_in   (ur_rad[k]),
        .rem_in   (ur_rem[k]),
        .root_in  (ur_root[k]),
        .rad_out  (ur_rad[k+1]),
        .rem_out  (ur_rem[k+1]),
        .root_out (ur_root[k+1])
      );
    end

    assign u_root[l] = ur_root[UROOT_W];
  end

  // magnitude root row, fed from the sum in parallel with the divide row
  logic [SW-1:0]   mg_rad  [MAGR+1];
  logic [MAGR+1:0] mg_rem  [MAGR+1];
  logic [MAGR-1:0] mg_root [MAGR+1];

  assign mg_rad[0]  = s2_sum;
  assign mg_rem[0]  = '0;
  assign mg_root[0] = '0;

  for (genvar k = 0; k < MAGR; k++) begin : g_mag
    v3n_sqrt_cell #(
      .N (SW),
      .R (MAGR)
    ) u_cell (
      .clk      (clk),
      .en       (en),
      .rad_in   (mg_rad[k]),
      .rem_in   (mg_rem[k]),
      .root_in  (mg_root[k]),
      .rad_out  (mg_rad[k+1]),
      .rem_out  (mg_rem[k+1]),
      .root_out (mg_root[k+1])
    );
  end

  // saturate the length to the output width
  logic [MAG_W-1:0] mag_sat;

  if (MAGR > MAG_W) begin : g_sat
    assign mag_sat = (|mg_root[MAGR][MAGR-1:MAG_W]) ? '1 : mg_root[MAGR][MAG_W-1:0];
  end else begin : g_nosat
    assign mag_sat = MAG_W'(mg_root[MAGR]);
  end

  // delay lines matching the divide and root rows
  logic [MAG_W-1:0] mag_dl [MAG_DELAY];
  lane_flags_t      fl_dl  [TOT];

  always_ff @(posedge clk) begin
    if (en) begin
      mag_dl[0] <= mag_sat;
      for (int i = 1; i < MAG_DELAY; i++) begin
        mag_dl[i] <= mag_dl[i-1];
      end
      fl_dl[0] <= fl_s2;
      for (int i = 1; i < TOT; i++) begin
        fl_dl[i] <= fl_dl[i-1];
      end
    end
  end

  // result: apply signs, force zeros for the zero vector
  lane_flags_t                  fl_out;
  logic [NLANE-1:0][UNIT_W-1:0] unit_v;

  assign fl_out = fl_dl[TOT-1];

  always_comb begin
    for (int l = 0; l < NLANE; l++) begin
      if (fl_out.zero) begin
        unit_v[l] = '0;
      end else if (fl_out.neg[l]) begin
        unit_v[l] = ~UNIT_W'(u_root[l]) + 1'b1;
      end else begin
        unit_v[l] = UNIT_W'(u_root[l]);
      end
    end
  end

  assign unit_x      = unit_v[0];
  assign unit_y      = unit_v[1];
  assign unit_z      = unit_v[2];
  assign magnitude   = fl_out.zero ? '0 : mag_dl[MAG_DELAY-1];
  assign zero_vector = fl_out.zero;

endmodule

>>> dv/vector3_normalize_test.sv
// Testbench for vector3_normalize: directed and random vectors checked against a predictor.
`timescale 1ns / 1ps

module vector3_normalize_test;
  import v3n_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int LATENCY     = 95;

  typedef struct {
    logic signed [UNIT_W-1:0] ux;
    logic signed [UNIT_W-1:0] uy;
    logic signed [UNIT_W-1:0] uz;
    logic [MAG_W-1:0]         mag;
    logic                     zero;
  } unit_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic vec_valid = 1'b0;
  logic vec_stall;
  logic signed [31:0] vec_x = '0;
  logic signed [31:0] vec_y = '0;
  logic signed [31:0] vec_z = '0;
  logic unit_valid;
  logic unit_stall = 1'b0;
  logic signed [UNIT_W-1:0] unit_x, unit_y, unit_z;
  logic [MAG_W-1:0] magnitude;
  logic zero_vector;

  unit_result_t pending_units[$];
  int  err_cnt    = 0;
  int  sent_cnt   = 0;
  int  recv_cnt   = 0;
  int  zero_cnt   = 0;
  int  cycle_cnt  = 0;
  bit  idle_en    = 1'b1;
  bit  hold_req   = 1'b0;

  vector3_normalize i_dut (
    .clk         (clk),
    .rst         (rst),
    .vec_valid   (vec_valid),
    .vec_stall   (vec_stall),
    .vec_x       (vec_x),
    .vec_y       (vec_y),
    .vec_z       (vec_z),
    .unit_valid  (unit_valid),
    .unit_stall  (unit_stall),
    .unit_x      (unit_x),
    .unit_y      (unit_y),
    .unit_z      (unit_z),
    .magnitude   (magnitude),
    .zero_vector (zero_vector)
  );

  always #5 clk = ~clk;

  // watchdog
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("vector3_normalize_test: done, errors");
      $finish;
    end
  end

  // floor(sqrt(v)), one root bit at a time from the top
  function automatic logic [127:0] root_floor(logic [127:0] v);
    logic [127:0] root;
    logic [127:0] cand;
    root = '0;
    for (int b = 63; b >= 0; b--) begin
      cand = root | (128'd1 << b);
      if (cand * cand <= v) root = cand;
    end
    return root;
  endfunction

  // component over exact length, Q1.30, truncated toward zero
  function automatic logic [31:0] unit_lane(logic signed [31:0] c, logic [127:0] sumsq);
    logic signed [63:0] cw;
    logic [63:0]  mag;
    logic [127:0] quo;
    logic [31:0]  u;
    cw  = c;
    mag = (cw < 0) ? -cw : cw;
    quo = ((128'(mag) * 128'(mag)) << 60) / sumsq;
    u   = 32'(root_floor(quo));
    return c[31] ? -u : u;
  endfunction

  function automatic unit_result_t normalize_vec(logic signed [31:0] x, logic signed [31:0] y,
                                                 logic signed [31:0] z);
    unit_result_t r;
    logic signed [63:0] xw, yw, zw;
    logic [127:0] sumsq;
    logic [127:0] m;
    xw = x;
    yw = y;
    zw = z;
    sumsq = 128'(xw * xw) + 128'(yw * yw) + 128'(zw * zw);
    if (sumsq == 0) begin
      r = '{ux: '0, uy: '0, uz: '0, mag: '0, zero: 1'b1};
    end else begin
      m = root_floor(sumsq);
      r.mag  = (m > 128'hFFFF_FFFF) ? 32'hFFFF_FFFF : m[31:0];
      r.ux   = unit_lane(x, sumsq);
      r.uy   = unit_lane(y, sumsq);
      r.uz   = unit_lane(z, sumsq);
      r.zero = 1'b0;
    end
    return r;
  endfunction

  // one vector transfer, with an optional random gap in front
  task automatic send_vec(logic signed [31:0] x, logic signed [31:0] y, logic signed [31:0] z);
    int gap;
    if (idle_en && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 8);
      vec_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    vec_valid <= 1'b1;
    vec_x <= x;
    vec_y <= y;
    vec_z <= z;
    @(posedge clk);
    while (vec_stall) @(posedge clk);
    pending_units.push_back(normalize_vec(x, y, z));
    sent_cnt++;
  endtask

  // receiver stall: random bursts, plus a long hold on request
  initial begin
    int stall_left;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req   = 1'b0;
        stall_left = 400;
      end
      if (stall_left > 0) begin
        unit_stall <= 1'b1;
        stall_left--;
      end else if (idle_en && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(0, 7);
        unit_stall <= 1'b1;
      end else begin
        unit_stall <= 1'b0;
      end
    end
  end

  // result check against the oldest prediction
  always @(posedge clk) begin
    unit_result_t want;
    if (!rst && unit_valid && !unit_stall) begin
      recv_cnt++;
      if (pending_units.size() == 0) begin
        err_cnt++;
        $error("unexpected result transfer");
      end else begin
        want = pending_units.pop_front();
        if (zero_vector) zero_cnt++;
        if (unit_x !== want.ux) begin
          err_cnt++;
          $error("unit_x expected %h actual %h", want.ux, unit_x);
        end
        if (unit_y !== want.uy) begin
          err_cnt++;
          $error("unit_y expected %h actual %h", want.uy, unit_y);
        end
        if (unit_z !== want.uz) begin
          err_cnt++;
          $error("unit_z expected %h actual %h", want.uz, unit_z);
        end
        if (magnitude !== want.mag) begin
          err_cnt++;
          $error("magnitude expected %h actual %h", want.mag, magnitude);
        end
        if (zero_vector !== want.zero) begin
          err_cnt++;
          $error("zero_vector expected %b actual %b", want.zero, zero_vector);
        end
      end
    end
  end

  // extremes, axis vectors and the zero vector
  task automatic test_directed();
    send_vec(0, 0, 0);
    send_vec(32'sh0001_0000, 0, 0);
    send_vec(0, -32'sh0001_0000, 0);
    send_vec(0, 0, 32'sh7FFF_FFFF);
    send_vec(32'sh8000_0000, 0, 0);
    send_vec(0, 32'sh8000_0000, 0);
    send_vec(0, 0, 32'sh8000_0000);
    send_vec(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
    send_vec(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000);
    send_vec(32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF);
    send_vec(1, 0, 0);
    send_vec(0, 0, -1);
    send_vec(1, 1, 1);
    send_vec(-1, -1, -1);
    send_vec(3, 4, 0);
    send_vec(-32'sh0003_0000, 32'sh0004_0000, 32'sh000C_0000);
    send_vec(0, 0, 0);
    send_vec(1, 32'sh8000_0000, 0);
    send_vec(-1, 0, 32'sh7FFF_FFFF);
  endtask

  // random content: full range, small values, sparse components
  task automatic test_random(int n);
    logic signed [31:0] c[3];
    for (int i = 0; i < n; i++) begin
      for (int k = 0; k < 3; k++) begin
        case ($urandom_range(0, 3))
          0: c[k] = $urandom;
          1: c[k] = $signed($urandom_range(0, 2000)) - 1000;
          2: c[k] = 0;
          default: c[k] = $signed($urandom) >>> $urandom_range(0, 30);
        endcase
      end
      send_vec(c[0], c[1], c[2]);
    end
  endtask

  // receiver holds off while the sender keeps offering items
  task automatic test_backpressure();
    hold_req = 1'b1;
    test_random(200);
  endtask

  // no idling on either side
  task automatic test_streaming();
    idle_en = 1'b0;
    test_random(150);
  endtask

  initial begin
    int waited;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_random(280);
    test_backpressure();
    test_streaming();
    vec_valid <= 1'b0;
    waited = 0;
    while (pending_units.size() != 0 && waited < 20000) begin
      @(posedge clk);
      waited++;
    end
    repeat (LATENCY + 10) @(posedge clk);
    $display("sent %0d vectors, checked %0d results (%0d zero vectors)",
             sent_cnt, recv_cnt, zero_cnt);
    $display("covered extremes, axis and zero vectors, random stalls and a long output hold");
    if (err_cnt == 0 && pending_units.size() == 0) begin
      $display("vector3_normalize_test: done, clean");
    end else begin
      $display("vector3_normalize_test: done, errors");
    end
    $finish;
  end

endmodule
